### sv/bpit_pkg.sv
`timescale 1ns / 1ps

package bpit_pkg;

    localparam int COORD_W = 16;
    localparam int WF_BITS = 16;
    localparam int WQ_W    = WF_BITS + 1;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int MAG_W   = SUM_W;
    localparam int NLANES  = 3;

    localparam logic [WQ_W-1:0] WEIGHT_ONE = WQ_W'(1) << WF_BITS;

    // One weight under division: partial remainder and quotient bits so far.
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [WQ_W-1:0]  quo;
    } lane_t;

    typedef struct packed {
        lane_t [NLANES-1:0] lane;
        logic [MAG_W-1:0]   den;
        logic               ok;
    } div_word_t;

endpackage

### sv/bpit_front.sv
`timescale 1ns / 1ps

module bpit_front import bpit_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] ax,
    input  logic signed [COORD_W-1:0] ay,
    input  logic signed [COORD_W-1:0] bx,
    input  logic signed [COORD_W-1:0] by_coord,
    input  logic signed [COORD_W-1:0] cx,
    input  logic signed [COORD_W-1:0] cy,
    input  logic signed [COORD_W-1:0] px,
    input  logic signed [COORD_W-1:0] py,
    output logic                      out_valid,
    input  logic                      out_ready,
    output div_word_t                 out_data
);

    function automatic logic signed [DIFF_W-1:0] dsub(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b);
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    // Stage 1: coordinate differences.
    logic signed [DIFF_W-1:0] d_reg [13];
    logic signed [DIFF_W-1:0] d_next [13];
    // Stage 2: products, den then na, nb, nc, two each.
    logic signed [PROD_W-1:0] p_reg [8];
    logic signed [PROD_W-1:0] p_next [8];
    // Stage 3: edge function sums, index 0 is the doubled area.
    logic signed [SUM_W-1:0]  s_reg [4];
    logic signed [SUM_W-1:0]  s_next [4];
    div_word_t                w_reg, w_next;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;

    assign r4       = !v4_reg || out_ready;
    assign r3       = !v3_reg || r4;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;
    assign out_valid = v4_reg;
    assign out_data  = w_reg;

    always_comb begin
        d_next[0]  = dsub(by_coord, cy);
        d_next[1]  = dsub(ax, bx);
        d_next[2]  = dsub(cx, bx);
        d_next[3]  = dsub(ay, by_coord);
        d_next[4]  = dsub(px, bx);
        d_next[5]  = dsub(py, by_coord);
        d_next[6]  = dsub(cy, ay);
        d_next[7]  = dsub(px, cx);
        d_next[8]  = dsub(ax, cx);
        d_next[9]  = dsub(py, cy);
        d_next[10] = dsub(px, ax);
        d_next[11] = dsub(bx, ax);
        d_next[12] = dsub(py, ay);
    end

    always_comb begin
        p_next[0] = d_reg[0] * d_reg[1];
        p_next[1] = d_reg[2] * d_reg[3];
        p_next[2] = d_reg[0] * d_reg[4];
        p_next[3] = d_reg[2] * d_reg[5];
        p_next[4] = d_reg[6] * d_reg[7];
        p_next[5] = d_reg[8] * d_reg[9];
        p_next[6] = d_reg[3] * d_reg[10];
        p_next[7] = d_reg[11] * d_reg[12];
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            s_next[i] = SUM_W'(p_reg[2*i]) + SUM_W'(p_reg[2*i+1]);
        end
    end

    // Stage 4: magnitudes and range checks, then seed each divider lane.
    always_comb begin
        logic                     den_neg;
        logic [MAG_W-1:0]         dmag;
        logic signed [SUM_W-1:0]  num;
        logic [MAG_W-1:0]         nmag;
        den_neg = s_reg[0][SUM_W-1];
        dmag    = den_neg ? MAG_W'(-s_reg[0]) : MAG_W'(s_reg[0]);
        w_next.den = dmag;
        w_next.ok  = (s_reg[0] != '0);
        for (int i = 0; i < NLANES; i++) begin
            num  = s_reg[i+1];
            nmag = num[SUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
            w_next.lane[i].rem = '0;
            w_next.lane[i].quo = '0;
            if (num != '0) begin
                if (num[SUM_W-1] != den_neg || nmag > dmag) begin
                    w_next.ok = 1'b0;
                end else if (nmag == dmag) begin
                    // Exactly one: a leading one that the shifts carry up.
                    w_next.lane[i].quo = WQ_W'(1);
                end else begin
                    w_next.lane[i].rem = nmag;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r1 && in_valid) d_reg <= d_next;
        if (r2 && v1_reg)   p_reg <= p_next;
        if (r3 && v2_reg)   s_reg <= s_next;
        if (r4 && v3_reg)   w_reg <= w_next;
    end

endmodule

### sv/bpit_div_cell.sv
`timescale 1ns / 1ps

module bpit_div_cell import bpit_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_word_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output div_word_t out_data
);

    logic      valid_reg;
    div_word_t data_reg, data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // One restoring division step for each of the three weights.
    always_comb begin
        logic [MAG_W:0] t;
        logic [MAG_W:0] d;
        data_next = in_data;
        d = {1'b0, in_data.den};
        for (int i = 0; i < NLANES; i++) begin
            t = {in_data.lane[i].rem, 1'b0};
            if (t >= d) begin
                data_next.lane[i].rem = MAG_W'(t - d);
                data_next.lane[i].quo = {in_data.lane[i].quo[WQ_W-2:0], 1'b1};
            end else begin
                data_next.lane[i].rem = t[MAG_W-1:0];
                data_next.lane[i].quo = {in_data.lane[i].quo[WQ_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) data_reg <= data_next;
    end

endmodule

### sv/barycentric_point_in_triangle.sv
`timescale 1ns / 1ps
// Point-in-triangle test with barycentric weights.
// Input channel s_*: corners A, B, C and query point P as signed 16-bit
// fixed point; an item is taken when s_valid and s_ready are both high.
// Result channel m_*: m_inside_res and three unsigned Q1.16 weights. When
// the point is outside, or the triangle has zero area, the result is
// inside 0 with weights 1.0, 0, 0.
// From acceptance to m_valid, four stages form the differences, products,
// edge sums and range checks, then a row of 16 division cells each
// produces one quotient bit of all three weights. Every stage has its own
// valid bit. Throughput is one item per cycle while m_ready is high.
// When the receiver holds m_ready low, the result stays on m_* and the
// stages behind it keep filling until each holds an item; only then does
// s_ready drop. Reset empties every stage, with no results pending.
module barycentric_point_in_triangle import bpit_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_ax,
    input  logic signed [COORD_W-1:0] s_ay,
    input  logic signed [COORD_W-1:0] s_bx,
    input  logic signed [COORD_W-1:0] s_by_coord,
    input  logic signed [COORD_W-1:0] s_cx,
    input  logic signed [COORD_W-1:0] s_cy,
    input  logic signed [COORD_W-1:0] s_px,
    input  logic signed [COORD_W-1:0] s_py,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_inside_res,
    output logic [WQ_W-1:0]           m_weight_a,
    output logic [WQ_W-1:0]           m_weight_b,
    output logic [WQ_W-1:0]           m_weight_c
);

    logic      c_valid [WF_BITS+1];
    logic      c_ready [WF_BITS+1];
    div_word_t c_data  [WF_BITS+1];

    bpit_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .ax        (s_ax),
        .ay        (s_ay),
        .bx        (s_bx),
        .by_coord  (s_by_coord),
        .cx        (s_cx),
        .cy        (s_cy),
        .px        (s_px),
        .py        (s_py),
        .out_valid (c_valid[0]),
        .out_ready (c_ready[0]),
        .out_data  (c_data[0])
    );

    for (genvar g = 0; g < WF_BITS; g++) begin : g_cell
        bpit_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (c_valid[g]),
            .in_ready  (c_ready[g]),
            .in_data   (c_data[g]),
            .out_valid (c_valid[g+1]),
            .out_ready (c_ready[g+1]),
            .out_data  (c_data[g+1])
        );
    end

    assign c_ready[WF_BITS] = m_ready;
    assign m_valid          = c_valid[WF_BITS];
    assign m_inside_res     = c_data[WF_BITS].ok;
    assign m_weight_a = c_data[WF_BITS].ok ? c_data[WF_BITS].lane[0].quo : WEIGHT_ONE;
    assign m_weight_b = c_data[WF_BITS].ok ? c_data[WF_BITS].lane[1].quo : '0;
    assign m_weight_c = c_data[WF_BITS].ok ? c_data[WF_BITS].lane[2].quo : '0;

endmodule

### sv/bpit_checker.sv
`timescale 1ns / 1ps

module bpit_checker import bpit_pkg::*; (
    input logic            aclk,
    input logic            aresetn,
    input logic            m_valid,
    input logic            m_ready,
    input logic            m_inside_res,
    input logic [WQ_W-1:0] m_weight_a,
    input logic [WQ_W-1:0] m_weight_b,
    input logic [WQ_W-1:0] m_weight_c
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_inside_res) && $stable(m_weight_a)
            && $stable(m_weight_b) && $stable(m_weight_c))
        else $error("stalled result changed");

    a_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_inside_res |->
            m_weight_a == WEIGHT_ONE && m_weight_b == '0 && m_weight_c == '0)
        else $error("outside result has wrong weights");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_inside_res |->
            m_weight_a <= WEIGHT_ONE && m_weight_b <= WEIGHT_ONE && m_weight_c <= WEIGHT_ONE)
        else $error("weight above one");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind barycentric_point_in_triangle bpit_checker u_bpit_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_inside_res (m_inside_res),
    .m_weight_a   (m_weight_a),
    .m_weight_b   (m_weight_b),
    .m_weight_c   (m_weight_c)
);
